/* rtl/urt_pkg.sv */
// ----------------------------------------------------------------------------
// urt_pkg
// Shared constants, types and the digit character table for the radix to
// text converter.
// ----------------------------------------------------------------------------
package urt_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int IN_W           = 64;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP       = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SHOW
    } urt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } urt_div_status_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

/* rtl/urt_if.sv */
// ----------------------------------------------------------------------------
// urt_num_if / urt_char_if
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface urt_num_if;
    logic                       valid;
    logic                       ready;
    logic [urt_pkg::IN_W-1:0]   number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface urt_char_if;
    logic                         valid;
    logic                         ready;
    logic [urt_pkg::CHAR_W-1:0]   digit_char;
    logic                         last_char;

    modport source (output valid, output digit_char, output last_char, input ready);
    modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface

/* rtl/urt_div_unit.sv */
// ----------------------------------------------------------------------------
// urt_div_unit
// Iterative restoring divider by a small radix, DIV_STEP quotient bits per
// cycle. Quotient and remainder are registered with the last step, as done rises.
// ----------------------------------------------------------------------------
module urt_div_unit #(
    parameter int VALUE_BITS = urt_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_BITS-1:0]        dividend,
    input  logic [urt_pkg::RADIX_W-1:0]  radix,
    output logic [VALUE_BITS-1:0]        quotient,
    output logic [urt_pkg::DIGIT_W-1:0]  remainder,
    output urt_pkg::urt_div_status_t     status
);
    import urt_pkg::*;

    localparam int DIV_BITS = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int CYCLES   = DIV_BITS / DIV_STEP;
    localparam int SW       = (CYCLES > 1) ? $clog2(CYCLES) : 1;

    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]  r_reg, r_next;
    logic [RADIX_W-1:0]  rad_reg;
    logic [SW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // DIV_STEP compare/subtract steps on the narrow partial remainder
    always_comb
    begin
        logic [DIV_BITS-1:0] q;
        logic [RADIX_W-1:0]  t;
        q = q_reg;
        t = r_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {t[RADIX_W-2:0], q[DIV_BITS-1]};
            q = {q[DIV_BITS-2:0], 1'b0};
            if (t >= rad_reg)
            begin
                t    = t - rad_reg;
                q[0] = 1'b1;
            end
        end
        q_next = q;
        r_next = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == SW'(CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= DIV_BITS'(dividend);
            r_reg   <= '0;
            rad_reg <= radix;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient    = q_reg[VALUE_BITS-1:0];
    assign remainder   = r_reg[DIGIT_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/urt_digit_store.sv */
// ----------------------------------------------------------------------------
// urt_digit_store
// Digit buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module urt_digit_store #(
    parameter int DEPTH = urt_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [urt_pkg::DIGIT_W-1:0]  wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [urt_pkg::DIGIT_W-1:0]  rdata
);
    import urt_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/unsigned_radix_to_text.sv */
// ----------------------------------------------------------------------------
// unsigned_radix_to_text
// Converts an unsigned value to ASCII digits in base 2..16, most significant
// digit first, one character per output word, last one flagged.
// ----------------------------------------------------------------------------
//  channel  dir  payload                         handshake
//  in_ch    in   number[63:0]                    valid/ready
//  out_ch   out  digit_char[6:0], last_char      valid/ready
//  cfg      in   cfg_wdata[4:0] (radix)          cfg_we, no wait
//
//  A value of D digits runs through the shared divider (4 quotient bits per
//  cycle, one division per digit), then each character takes a digit
//  buffer read, then an output hold.
//  64-bit value in base ten: up to 20 digits.
//  in_ch.ready is high only between values; output stalls hold the word.
//  Reset sets the radix to ten; the digit buffer needs no clearing.
// ----------------------------------------------------------------------------
module unsigned_radix_to_text #(
    parameter int VALUE_BITS = urt_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [urt_pkg::RADIX_W-1:0]   cfg_wdata,
    urt_num_if.sink                       in_ch,
    urt_char_if.source                    out_ch
);
    import urt_pkg::*;

    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    urt_state_t          state_reg, state_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  radix_eff;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;

    logic                div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIGIT_W-1:0]  div_rem;
    urt_div_status_t     div_status;

    logic                mem_we;
    logic                mem_re;
    logic [DIGIT_W-1:0]  mem_rdata;

    logic                in_fire;
    logic                out_fire;
    logic                stop;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    // drop the loop on a zero quotient or a full buffer
    assign stop     = (div_quot == '0) || (count_reg + 1'b1 == CNT_W'(VALUE_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_we)
            radix_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_status.done && stop)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_SHOW;
            ST_SHOW:
                if (out_fire)
                    state_next = (rd_addr_reg == '0) ? ST_IDLE : ST_READ;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quot;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        count_next   = count_reg;
        rd_addr_next = rd_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // ready is high here, so a valid word is taken
                in_ch.ready  = 1'b1;
                div_dividend = in_ch.number[VALUE_BITS-1:0];
                div_start    = in_ch.valid;
                count_next   = '0;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (stop)
                        rd_addr_next = count_reg[ADDR_W-1:0];
                    else
                        div_start = 1'b1;
                end
            end
            ST_READ:
                mem_re = 1'b1;
            ST_SHOW:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready && rd_addr_reg != '0)
                    rd_addr_next = rd_addr_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    assign out_ch.digit_char = digit_to_char(mem_rdata);
    assign out_ch.last_char  = (rd_addr_reg == '0);

    urt_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_eff),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_status)
    );

    urt_digit_store #(
        .DEPTH (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (div_rem),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

endmodule

/* rtl/urt_checker.sv */
// ----------------------------------------------------------------------------
// urt_checker
// Port-level checks for the radix to text converter, bound to the top level.
// ----------------------------------------------------------------------------
module urt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [urt_pkg::CHAR_W-1:0]   digit_char,
    input logic                         last_char
);
    import urt_pkg::*;

    // one value at a time: no new word while characters are pending
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a character is pending");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a value was taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digit_char)
                                       && $stable(last_char)))
        else $error("stalled output word changed");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((digit_char >= 7'h30 && digit_char <= 7'h39)
                    || (digit_char >= 7'h61 && digit_char <= 7'h66)))
        else $error("character outside digit set");

    a_end_of_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_char) |=> (!out_valid && in_ready))
        else $error("output continues after last character");

endmodule

bind unsigned_radix_to_text urt_checker u_urt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .digit_char (out_ch.digit_char),
    .last_char  (out_ch.last_char)
);
